[hdl/tlpd_pkg.sv]
// Shared types, constants and helpers for the typed length-prefixed deframer.
`default_nettype none

package tlpd_pkg;

  // Frame layout
  localparam int unsigned HeaderBytes = 13;
  localparam int unsigned SeqLastPos  = 8;
  localparam int unsigned HdrCntW     = 4;
  localparam int unsigned LengthBits  = 32;
  localparam int unsigned SeqW        = 64;

  // Known frame types
  localparam logic [7:0] TypeRgb   = 8'h01;
  localparam logic [7:0] TypeDepth = 8'h02;
  localparam logic [7:0] TypeImu   = 8'h03;
  localparam logic [7:0] TypeCloud = 8'h08;
  localparam logic [7:0] TypeConf  = 8'h09;

  typedef enum logic [2:0] {
    ChRgb     = 3'd0,
    ChDepth   = 3'd1,
    ChImu     = 3'd2,
    ChCloud   = 3'd3,
    ChConf    = 3'd4,
    ChUnknown = 3'd5
  } channel_e;

  // One output word
  typedef struct packed {
    channel_e         channel;
    logic [7:0]       payload_byte;
    logic             byte_present;
    logic [SeqW-1:0]  sequence_res;
    logic             frame_last;
  } result_t;

  // Map a frame type byte to its channel code
  function automatic channel_e channel_of(input logic [7:0] t);
    channel_e ch;
    case (t)
      TypeRgb:   ch = ChRgb;
      TypeDepth: ch = ChDepth;
      TypeImu:   ch = ChImu;
      TypeCloud: ch = ChCloud;
      TypeConf:  ch = ChConf;
      default:   ch = ChUnknown;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[hdl/typed_length_prefixed_deframer_top.sv]
// Top level of the typed length-prefixed deframer.
// A result is registered into the output buffer when its byte is accepted.
// One byte per cycle while in_ready_o is high; the parser steps on each byte.
// A two-word output buffer takes one more word while the output stalls.
// Reset (rst_ni low, asynchronous) returns the parser to header byte zero
// and empties the output buffer.
`default_nettype none

module typed_length_prefixed_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       channel_o,
  output logic [7:0]       payload_byte_o,
  output logic             byte_present_o,
  output logic [63:0]      sequence_res_o,
  output logic             frame_last_o
);

  logic              accept;
  logic              push;
  tlpd_pkg::result_t push_word;
  tlpd_pkg::result_t out_word;

  assign accept = in_valid_i && in_ready_o;

  tlpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .result_o    (push_word)
  );

  tlpd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .word_o      (out_word)
  );

  assign channel_o      = out_word.channel;
  assign payload_byte_o = out_word.payload_byte;
  assign byte_present_o = out_word.byte_present;
  assign sequence_res_o = out_word.sequence_res;
  assign frame_last_o   = out_word.frame_last;

  // Input only backs up when both buffer words are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Empty markers always close a frame
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_present_o) |-> (frame_last_o && payload_byte_o == 8'h00))
    else $error("marker word without last flag or with data");

  // Unknown frames never pass bytes
  a_unknown_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && channel_o == tlpd_pkg::ChUnknown) |-> !byte_present_o)
    else $error("byte passed on unknown channel");

  // A full buffer that is drained frees the input next cycle
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && out_ready_i) |=> in_ready_o)
    else $error("input not released after drain");

endmodule

`default_nettype wire

[hdl/tlpd_core.sv]
// Header parser and payload counter: consumes one stream byte per accept.
`default_nettype none

module tlpd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  output logic                   push_o,
  output tlpd_pkg::result_t      result_o
);

  localparam int unsigned LenW = tlpd_pkg::LengthBits;

  logic                           in_payload_q, in_payload_d;
  logic [tlpd_pkg::HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  tlpd_pkg::channel_e             chan_q, chan_d;
  logic [tlpd_pkg::SeqW-1:0]      seq_q, seq_d;
  logic [LenW-1:0]                len_q, len_d;
  logic [LenW-1:0]                left_q, left_d;

  logic [LenW-1:0]                len_shift;
  logic [LenW-1:0]                left_dec;
  logic                           hdr_done;

  // length keeps only its low LenW bits
  assign len_shift = LenW'({len_q, data_byte_i});
  assign left_dec  = left_q - LenW'(1);
  assign hdr_done  = (hdr_cnt_q == tlpd_pkg::HdrCntW'(tlpd_pkg::HeaderBytes - 1));

  // Next state
  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    chan_d       = chan_q;
    seq_d        = seq_q;
    len_d        = len_q;
    left_d       = left_q;
    if (accept_i) begin
      if (!in_payload_q) begin
        if (hdr_cnt_q == '0) begin
          chan_d = tlpd_pkg::channel_of(data_byte_i);
          seq_d  = '0;
          len_d  = '0;
        end else if (hdr_cnt_q <= tlpd_pkg::HdrCntW'(tlpd_pkg::SeqLastPos)) begin
          seq_d = {seq_q[tlpd_pkg::SeqW-9:0], data_byte_i};
        end else begin
          len_d = len_shift[LenW-1:0];
        end
        if (hdr_done) begin
          hdr_cnt_d = '0;
          if (len_shift[LenW-1:0] != '0) begin
            left_d       = len_shift[LenW-1:0];
            in_payload_d = 1'b1;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + tlpd_pkg::HdrCntW'(1);
        end
      end else begin
        left_d = left_dec;
        if (left_dec == '0) begin
          in_payload_d = 1'b0;
          hdr_cnt_d    = '0;
        end
      end
    end
  end

  // Result word for this byte
  always_comb begin
    push_o                = 1'b0;
    result_o.channel      = chan_q;
    result_o.payload_byte = 8'h00;
    result_o.byte_present = 1'b0;
    result_o.sequence_res = seq_q;
    result_o.frame_last   = 1'b1;
    if (accept_i) begin
      if (!in_payload_q) begin
        // empty frame marker at the last header byte
        if (hdr_done && (len_shift[LenW-1:0] == '0)) begin
          push_o = 1'b1;
        end
      end else if (chan_q == tlpd_pkg::ChUnknown) begin
        // unknown type: only its end shows up
        push_o = (left_dec == '0);
      end else begin
        push_o                = 1'b1;
        result_o.payload_byte = data_byte_i;
        result_o.byte_present = 1'b1;
        result_o.frame_last   = (left_dec == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      chan_q       <= tlpd_pkg::ChRgb;
      left_q       <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      chan_q       <= chan_d;
      left_q       <= left_d;
    end
  end

  // header payload registers
  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    len_q <= len_d;
  end

endmodule

`default_nettype wire

[hdl/tlpd_outbuf.sv]
// Two-word output buffer: output register plus skid register.
`default_nettype none

module tlpd_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tlpd_pkg::result_t push_word_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output tlpd_pkg::result_t      word_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tlpd_pkg::result_t out_q, out_d;
  tlpd_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign word_o  = out_q;

  // Buffer update: keep word order, skid only fills while output stalls
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_word_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_word_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = push_word_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire
